FILE: src/assert_macros.svh
// assertion macros shared by the hash engine modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while in reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/mm64_pkg.sv
// ----------------------------------------------------------------------------
// mm64_pkg
// Shared constants, controller states and the command/status bundles that
// join the controller and the datapath of the 64-bit hash engine.
// ----------------------------------------------------------------------------
package mm64_pkg;

    // mixing constants
    localparam logic [63:0] MIX_MUL = 64'hc6a4a7935bd1e995;
    localparam int unsigned MIX_SHR = 47;

    // field widths
    localparam int unsigned WORD_W  = 64;
    localparam int unsigned NVAL_W  = 4;
    localparam int unsigned SEED_W  = 64;
    localparam int unsigned LEN_W   = 32;
    localparam int unsigned HALF_W  = 32;
    localparam int unsigned TDATA_W = 168;

    // multiplier phases: low x low, low x high, high x low
    localparam logic [1:0] PH_LL = 2'd0;
    localparam logic [1:0] PH_LH = 2'd1;
    localparam logic [1:0] PH_HL = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_LEN_MUL,
        ST_K1_MUL,
        ST_K2_MUL,
        ST_H_MUL,
        ST_TAIL,
        ST_FIN_SHIFT,
        ST_FIN_MUL
    } ctrl_state_t;

    // multiplier operand and write-back selection
    typedef enum logic [2:0] {
        MSEL_LEN,
        MSEL_WORD,
        MSEL_K,
        MSEL_H,
        MSEL_FIN
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     tail_xor;
        logic     fin_shift;
    } dp_cmd_t;

    typedef struct packed {
        logic first;
        logic last;
        logic full;
        logic tail;
        logic mul_last;
        logic mul_idle;
        logic out_free;
    } dp_status_t;

endpackage

FILE: src/mm64_datapath.sv
// ----------------------------------------------------------------------------
// mm64_datapath
// Word, key and hash registers, a shared 32x32 multiplier that forms a product
// by the mixing constant from partial products in phases, and the result register.
// ----------------------------------------------------------------------------
module mm64_datapath
    import mm64_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  dp_cmd_t             cmd,
    output dp_status_t          status,
    input  logic [WORD_W-1:0]   in_data_word,
    input  logic [NVAL_W-1:0]   in_valid_bytes,
    input  logic                in_first_word,
    input  logic                in_last_word,
    input  logic [SEED_W-1:0]   in_seed,
    input  logic [LEN_W-1:0]    in_message_length,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [WORD_W-1:0]   m_hash_value
);

    `include "assert_macros.svh"

    logic [WORD_W-1:0]   word_reg;
    logic [SEED_W-1:0]   seed_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [NVAL_W-1:0]   nvalid_reg;
    logic                first_reg;
    logic                last_reg;
    logic [WORD_W-1:0]   k_reg, k_next;
    logic [WORD_W-1:0]   h_reg, h_next;
    logic [WORD_W-1:0]   acc_reg, acc_next;
    logic [1:0]          phase_reg, phase_next;
    logic [WORD_W-1:0]   hash_reg, hash_next;
    logic                m_tvalid_reg, m_tvalid_next;

    logic [WORD_W-1:0]   mul_x;
    logic [HALF_W-1:0]   mul_a, mul_b;
    logic [WORD_W-1:0]   mul_prod;
    logic [WORD_W-1:0]   mul_sum;
    logic [WORD_W-1:0]   mul_res_shr;
    logic [WORD_W-1:0]   tail_bits;
    logic                mul_wb;
    logic                fin_wb;

    // input capture on an accepted transaction
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            word_reg   <= in_data_word;
            seed_reg   <= in_seed;
            len_reg    <= in_message_length;
            nvalid_reg <= in_valid_bytes;
            first_reg  <= in_first_word;
            last_reg   <= in_last_word;
        end
    end

    // multiplier operand
    always_comb begin
        case (cmd.mul_sel)
            MSEL_LEN:  mul_x = {{(WORD_W-LEN_W){1'b0}}, len_reg};
            MSEL_WORD: mul_x = word_reg;
            MSEL_K:    mul_x = k_reg;
            default:   mul_x = h_reg;
        endcase
    end

    // one partial product per phase, summed into the accumulator
    always_comb begin
        case (phase_reg)
            PH_LL: begin
                mul_a = mul_x[HALF_W-1:0];
                mul_b = MIX_MUL[HALF_W-1:0];
            end
            PH_LH: begin
                mul_a = mul_x[HALF_W-1:0];
                mul_b = MIX_MUL[WORD_W-1:HALF_W];
            end
            default: begin
                mul_a = mul_x[WORD_W-1:HALF_W];
                mul_b = MIX_MUL[HALF_W-1:0];
            end
        endcase
        mul_prod    = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
        mul_sum     = (phase_reg == PH_LL) ? mul_prod
                    : acc_reg + {mul_prod[HALF_W-1:0], {HALF_W{1'b0}}};
        mul_res_shr = mul_sum ^ (mul_sum >> MIX_SHR);
        mul_wb      = cmd.mul_en && (phase_reg == PH_HL);
        fin_wb      = mul_wb && (cmd.mul_sel == MSEL_FIN);
    end

    // tail bytes of a short last word
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            tail_bits[8*i +: 8] = (3'(i) < nvalid_reg[2:0]) ? word_reg[8*i +: 8] : 8'h00;
        end
    end

    // next values of the working registers
    always_comb begin
        k_next        = k_reg;
        h_next        = h_reg;
        hash_next     = hash_reg;
        acc_next      = acc_reg;
        phase_next    = phase_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        if (cmd.mul_en) begin
            acc_next   = mul_sum;
            phase_next = (phase_reg == PH_HL) ? PH_LL : phase_reg + 2'd1;
        end

        if (mul_wb) begin
            case (cmd.mul_sel)
                MSEL_LEN:  h_next = seed_reg ^ mul_sum;
                MSEL_WORD: k_next = mul_res_shr;
                MSEL_K:    h_next = h_reg ^ mul_sum;
                MSEL_H:    h_next = mul_sum;
                MSEL_FIN: begin
                    hash_next     = mul_res_shr;
                    m_tvalid_next = 1'b1;
                    h_next        = '0;
                end
                default: h_next = h_reg;
            endcase
        end

        if (cmd.tail_xor) begin
            h_next = h_reg ^ tail_bits;
        end
        if (cmd.fin_shift) begin
            h_next = h_reg ^ (h_reg >> MIX_SHR);
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_reg        <= '0;
            phase_reg    <= PH_LL;
            m_tvalid_reg <= 1'b0;
        end else begin
            h_reg        <= h_next;
            phase_reg    <= phase_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        k_reg    <= k_next;
        acc_reg  <= acc_next;
        hash_reg <= hash_next;
    end

    // status toward the controller
    always_comb begin
        status.first    = first_reg;
        status.last     = last_reg;
        status.full     = !last_reg || nvalid_reg[3];
        status.tail     = last_reg && !nvalid_reg[3] && (nvalid_reg[2:0] != 3'd0);
        status.mul_last = (phase_reg == PH_HL);
        status.mul_idle = (phase_reg == PH_LL);
        status.out_free = !m_tvalid_reg || m_tready;
    end

    assign m_tvalid     = m_tvalid_reg;
    assign m_hash_value = hash_reg;

    `ASSERT_SAME(a_load_phase_idle, cmd.load, phase_reg == PH_LL, "load during a multiply")
    `ASSERT_SAME(a_fin_out_empty, fin_wb, !m_tvalid_reg, "result overwrites a pending one")
    `ASSERT_NEXT(a_fin_clears_hash, fin_wb, m_tvalid_reg && (h_reg == '0), "final not cleared")

endmodule

FILE: src/mm64_ctrl.sv
// ----------------------------------------------------------------------------
// mm64_ctrl
// Sequencer of the hash engine: accepts one word, steps the datapath through
// start, mix, tail and finalize operations, then returns to idle.
// ----------------------------------------------------------------------------
module mm64_ctrl
    import mm64_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    `include "assert_macros.svh"

    ctrl_state_t state_reg, state_next;
    ctrl_state_t body_state;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        if (status.full) begin
            body_state = ST_K1_MUL;
        end else if (status.tail) begin
            body_state = ST_TAIL;
        end else begin
            body_state = ST_FIN_SHIFT;
        end

        state_next    = state_reg;
        s_tready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.mul_en    = 1'b0;
        cmd.mul_sel   = MSEL_H;
        cmd.tail_xor  = 1'b0;
        cmd.fin_shift = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                state_next = status.first ? ST_LEN_MUL : body_state;
            end
            ST_LEN_MUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_LEN;
                if (status.mul_last) begin
                    state_next = body_state;
                end
            end
            ST_K1_MUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_WORD;
                if (status.mul_last) begin
                    state_next = ST_K2_MUL;
                end
            end
            ST_K2_MUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_K;
                if (status.mul_last) begin
                    state_next = ST_H_MUL;
                end
            end
            ST_TAIL: begin
                cmd.tail_xor = 1'b1;
                state_next   = ST_H_MUL;
            end
            ST_H_MUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_H;
                if (status.mul_last) begin
                    state_next = status.last ? ST_FIN_SHIFT : ST_IDLE;
                end
            end
            ST_FIN_SHIFT: begin
                // wait here until the result register can take a new hash
                if (status.out_free) begin
                    cmd.fin_shift = 1'b1;
                    state_next    = ST_FIN_MUL;
                end
            end
            ST_FIN_MUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_FIN;
                if (status.mul_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_SAME(a_idle_mul_idle, state_reg == ST_IDLE, status.mul_idle, "idle mid-multiply")
    `ASSERT_NEXT(a_load_starts, cmd.load, state_reg == ST_START, "accept did not start")
    `ASSERT_SAME(a_fin_mul_free, state_reg == ST_FIN_MUL, status.out_free, "final with full output")

endmodule

FILE: src/murmur64a_hash.sv
// ----------------------------------------------------------------------------
// murmur64a_hash
// MurmurHash64A engine for a byte message streamed as little-endian 64-bit
// words, with one hash transaction out per message.
// ----------------------------------------------------------------------------
// Each word runs alone through a controller and a datapath that share one
// 32x32 multiplier; every product by the mixing constant is formed there in
// phases, and that multiplier sets the rate. A word passes through accept and
// dispatch, then a length product if it opens a message, then two key products
// and a hash product for a full word or a tail XOR and a hash product for a
// short tail, then a shift and a final product for finalizing a last word. The
// finished hash waits in an output register, and the next word is taken while
// it waits; a further finalize stalls only if the earlier hash is not yet taken.
// ----------------------------------------------------------------------------
module murmur64a_hash
    import mm64_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // input stream
    input  logic               s_tvalid,
    output logic               s_tready,
    // data_word[63:0], valid_bytes[67:64], seed[131:68], message_length[163:132]
    input  logic [TDATA_W-1:0] s_tdata,
    // last_word
    input  logic               s_tlast,
    // first_word
    input  logic [0:0]         s_tuser,
    // result stream
    output logic               m_tvalid,
    input  logic               m_tready,
    // hash_value[63:0]
    output logic [WORD_W-1:0]  m_tdata
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer
    mm64_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath, unpacking the input transaction fields
    mm64_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .in_data_word      (s_tdata[63:0]),
        .in_valid_bytes    (s_tdata[67:64]),
        .in_first_word     (s_tuser[0]),
        .in_last_word      (s_tlast),
        .in_seed           (s_tdata[131:68]),
        .in_message_length (s_tdata[163:132]),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_hash_value      (m_tdata)
    );

endmodule

FILE: dv/murmur64a_hash_tb.sv
// ----------------------------------------------------------------------------
// murmur64a_hash_tb
// Self-checking bench for the streamed 64-bit hash engine. Words go in on the
// input stream with random gaps and the results are taken with random
// back-pressure. A local bit-accurate hash predictor queues one expected hash
// for every accepted last word, and each result transaction is compared
// against the oldest queued hash.
// ----------------------------------------------------------------------------
module murmur64a_hash_tb;
    import mm64_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned RANDOM_WORDS = 1800;
    localparam int unsigned QUIET_AFTER  = 1500;
    localparam int unsigned MAX_IDLE     = 13;
    localparam int unsigned FULL_BYTES   = 8;
    localparam int unsigned DRAIN_CYCLES = 40;

    // one input word with its side fields
    typedef struct {
        logic [WORD_W-1:0] data;
        logic [NVAL_W-1:0] nvalid;
        logic              first;
        logic              last;
        logic [SEED_W-1:0] seed;
        logic [LEN_W-1:0]  len;
    } hash_word_t;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;
    logic               s_tlast;
    logic [0:0]         s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [WORD_W-1:0]  m_tdata;

    // predictor state and expected hashes in arrival order
    logic [63:0]  open_hash;
    logic [63:0]  pending_hashes[$];
    logic [63:0]  oldest_hash;
    int unsigned  words_sent;
    int unsigned  err_count;
    int unsigned  cycle_count;
    int unsigned  gap_pct;
    int unsigned  stall_pct;

    murmur64a_hash dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hash arithmetic, all modulo 2^64
    function automatic logic [63:0] scramble_key(input logic [63:0] k);
        logic [63:0] x;
        x = k * MIX_MUL;
        x = x ^ (x >> MIX_SHR);
        x = x * MIX_MUL;
        return x;
    endfunction

    function automatic logic [63:0] absorb_word(input logic [63:0] h, input logic [63:0] k);
        logic [63:0] x;
        x = (h ^ scramble_key(k)) * MIX_MUL;
        return x;
    endfunction

    function automatic logic [63:0] avalanche(input logic [63:0] h);
        logic [63:0] x;
        x = h ^ (h >> MIX_SHR);
        x = x * MIX_MUL;
        x = x ^ (x >> MIX_SHR);
        return x;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // advance the running hash by one accepted word, queue the hash on a last word
    task automatic fold_word(input hash_word_t w);
        logic [63:0]  h;
        logic [63:0]  mask;
        int unsigned  nv;
        h = w.first ? (w.seed ^ ({32'd0, w.len} * MIX_MUL)) : open_hash;
        if (!w.last) begin
            open_hash = absorb_word(h, w.data);
        end else begin
            nv = (w.nvalid > FULL_BYTES) ? FULL_BYTES : w.nvalid;
            if (nv == FULL_BYTES) begin
                h = absorb_word(h, w.data);
            end else if (nv != 0) begin
                mask = (64'd1 << (8 * nv)) - 64'd1;
                h = (h ^ (w.data & mask)) * MIX_MUL;
            end
            pending_hashes.push_back(avalanche(h));
            open_hash = '0;
        end
    endtask

    // present one word, wait for its transaction, then predict
    task automatic send_word(input hash_word_t w);
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, MAX_IDLE)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, w.len, w.seed, w.nvalid, w.data};
        s_tlast  <= w.last;
        s_tuser  <= w.first;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        fold_word(w);
        words_sent++;
    endtask

    // hold off the input until every queued hash has come out
    task automatic wait_all_hashes();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_hashes.size() != 0) @(posedge aclk);
    endtask

    // one message: first word carries seed and length field, last word the tail
    task automatic send_message(input int unsigned nbytes, input logic [31:0] len_field,
                                input logic [63:0] seed);
        int unsigned nwords;
        hash_word_t  w;
        nwords = (nbytes == 0) ? 1 : (nbytes + 7) / 8;
        for (int i = 0; i < nwords; i++) begin
            w.data   = rand64();
            w.first  = (i == 0);
            w.last   = (i == nwords - 1);
            w.seed   = (i == 0) ? seed : rand64();
            w.len    = (i == 0) ? len_field : $urandom;
            w.nvalid = w.last ? 4'(nbytes - 8 * i) : 4'($urandom_range(0, 15));
            send_word(w);
        end
    endtask

    // words with no first flag straight after reset continue from a zero hash
    task automatic test_after_reset();
        hash_word_t w;
        w = '{data: rand64(), nvalid: 4'd0, first: 1'b0, last: 1'b0,
              seed: rand64(), len: $urandom};
        send_word(w);
        w = '{data: rand64(), nvalid: 4'd3, first: 1'b0, last: 1'b1,
              seed: rand64(), len: $urandom};
        send_word(w);
    endtask

    // single-word messages over every valid_bytes code, saturating ones included
    task automatic test_tail_sizes();
        hash_word_t w;
        for (int nv = 0; nv < 16; nv++) begin
            w.data   = rand64();
            w.nvalid = 4'(nv);
            w.first  = 1'b1;
            w.last   = 1'b1;
            w.seed   = rand64();
            w.len    = (nv > FULL_BYTES) ? FULL_BYTES : nv;
            send_word(w);
        end
    endtask

    // all-zero and all-one fields
    task automatic test_extremes();
        hash_word_t w;
        w = '{data: '0, nvalid: 4'd8, first: 1'b1, last: 1'b1, seed: '0, len: '0};
        send_word(w);
        w = '{data: '1, nvalid: 4'd15, first: 1'b1, last: 1'b1, seed: '1, len: '1};
        send_word(w);
    endtask

    // a first word abandons an open message; afterwards a bare word starts from zero
    task automatic test_restart();
        hash_word_t w;
        w = '{data: rand64(), nvalid: 4'd8, first: 1'b1, last: 1'b0, seed: rand64(), len: 32'd24};
        send_word(w);
        w = '{data: rand64(), nvalid: 4'd2, first: 1'b0, last: 1'b0, seed: rand64(), len: $urandom};
        send_word(w);
        w = '{data: rand64(), nvalid: 4'd8, first: 1'b1, last: 1'b0, seed: rand64(), len: 32'd16};
        send_word(w);
        w = '{data: rand64(), nvalid: 4'd8, first: 1'b0, last: 1'b0, seed: rand64(), len: $urandom};
        send_word(w);
        w = '{data: rand64(), nvalid: 4'd8, first: 1'b0, last: 1'b1, seed: rand64(), len: $urandom};
        send_word(w);
        w = '{data: rand64(), nvalid: 4'd5, first: 1'b0, last: 1'b1, seed: rand64(), len: $urandom};
        send_word(w);
    endtask

    // mostly well-formed messages, some stray words and wrong length fields
    task automatic test_random_messages();
        int unsigned base;
        int unsigned pick;
        int unsigned nbytes;
        logic [31:0] len_field;
        logic [63:0] seed;
        hash_word_t  w;
        bit          paused;
        base   = words_sent;
        paused = 1'b0;
        while (words_sent - base < RANDOM_WORDS) begin
            // idle rates change per message; the tail of the run is idle free
            if (words_sent - base >= QUIET_AFTER) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                case ($urandom_range(0, 3))
                    0: gap_pct = 0;
                    1: gap_pct = 10;
                    2: gap_pct = 30;
                    default: gap_pct = 60;
                endcase
                stall_pct = $urandom_range(0, 3) * 10;
            end
            if (!paused && words_sent - base >= RANDOM_WORDS / 2) begin
                wait_all_hashes();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                w.data   = rand64();
                w.nvalid = 4'($urandom_range(0, 15));
                w.first  = 1'($urandom_range(0, 1));
                w.last   = 1'($urandom_range(0, 1));
                w.seed   = rand64();
                w.len    = $urandom;
                send_word(w);
            end else begin
                nbytes = (pick == 1) ? $urandom_range(0, 256) : $urandom_range(0, 40);
                len_field = ($urandom_range(0, 7) == 0) ? 32'($urandom) : 32'(nbytes);
                case ($urandom_range(0, 9))
                    0: seed = '0;
                    1: seed = '1;
                    default: seed = rand64();
                endcase
                send_message(nbytes, len_field, seed);
            end
        end
    endtask

    // receiver back-pressure in random bursts
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, MAX_IDLE)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // compare each result transaction with the oldest expected hash
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_hashes.size() == 0) begin
                $error("hash_value: no hash expected, actual %h", m_tdata);
                err_count++;
            end else begin
                oldest_hash = pending_hashes.pop_front();
                if (m_tdata !== oldest_hash) begin
                    $error("hash_value: expected %h, actual %h", oldest_hash, m_tdata);
                    err_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // test sequence
    initial begin
        aresetn    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tlast    <= 1'b0;
        s_tuser    <= '0;
        open_hash   = '0;
        words_sent  = 0;
        err_count   = 0;
        cycle_count = 0;
        gap_pct     = 20;
        stall_pct   = 20;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_after_reset();
        test_tail_sizes();
        test_extremes();
        test_restart();
        wait_all_hashes();
        test_random_messages();

        // let the last hashes out, then drain before the verdict
        wait_all_hashes();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
